// ===== rtl/fir80_pkg.sv =====
// Shared types, defaults and coefficient ROM for the 80-tap low-pass FIR.
package fir80_pkg;

  localparam int TAPS_DEF        = 80;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 18;

  localparam int ROM_HALF = 40;
  localparam int ROM_LEN  = 80;
  localparam int ROM_BITS = 18;

  // First half of the symmetric Q1.17 coefficient set; the second half mirrors it.
  localparam int ROM_HALF_TBL [ROM_HALF] = '{
       -16,     56,     95,     68,    -23,   -123,   -152,    -59,
       121,    261,    224,    -23,   -336,   -464,   -234,    268,
       695,    660,     58,   -760,  -1164,   -707,    458,   1544,
      1632,    391,  -1494,  -2636,  -1896,    631,   3363,   4097,
      1581,  -3229,  -7192,  -6554,    734,  13363,  26821,  35474
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear;
    logic tap_vld;
    logic last;
  } mac_ctl_t;

  // Coefficient of one tap, rescaled to coef_bits; taps past the table are zero.
  function automatic int coef_at(int idx, int coef_bits);
    int c;
    int s;
    if (idx >= ROM_LEN) begin
      return 0;
    end
    c = ROM_HALF_TBL[(idx < ROM_HALF) ? idx : (ROM_LEN - 1 - idx)];
    if (coef_bits >= ROM_BITS) begin
      return c <<< (coef_bits - ROM_BITS);
    end
    s = ROM_BITS - coef_bits;
    return (c + (1 <<< (s - 1))) >>> s;
  endfunction

endpackage

// ===== rtl/fir80_mac.sv =====
// Pipelined multiply-accumulate with round, shift and saturate of the sum.
module fir80_mac #(
  parameter int TAPS        = fir80_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fir80_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = fir80_pkg::COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fir80_pkg::mac_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] samp,
  input  logic signed [COEF_BITS-1:0]   coef,
  output logic signed [SAMPLE_BITS-1:0] y,
  output logic                          done
);
  import fir80_pkg::*;

  localparam int ACC_W  = SAMPLE_BITS + COEF_BITS + $clog2(TAPS) + 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int FRAC   = COEF_BITS - 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] HI   = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LO   = -(ACC_W'(1) << (SAMPLE_BITS - 1));

  logic                          s1_vld_r, s1_last_r;
  logic                          s2_vld_r, s2_last_r;
  logic                          done_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic signed [COEF_BITS-1:0]   coef_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       shd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_vld_r  <= 1'b0;
      s2_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      s1_vld_r  <= ctl.tap_vld;
      s1_last_r <= ctl.tap_vld & ctl.last;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      done_r    <= s2_vld_r & s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    samp_r <= samp;
    coef_r <= coef;
    prod_r <= samp_r * coef_r;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Round half up, drop the fraction, clamp to the sample range.
  always_comb begin
    rnd = acc_r + HALF;
    shd = rnd >>> FRAC;
    if (shd > HI) begin
      y = HI[SAMPLE_BITS-1:0];
    end else if (shd < LO) begin
      y = LO[SAMPLE_BITS-1:0];
    end else begin
      y = shd[SAMPLE_BITS-1:0];
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/fir_lowpass_80_tap_unit.sv =====
// Top level of the 80-tap low-pass FIR: delay line, tap sequencer and output register.
// One shared multiplier serves one tap a cycle while the delay line rotates past it, and a
// new beat is accepted only in idle, once the previous sample is in the output register.
// A result waiting in the output register does not block acceptance of the next beat.
// Reset (rst_n low, synchronous) clears the delay line to zero and empties the output.
module fir_lowpass_80_tap_unit #(
  parameter int TAPS        = fir80_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fir80_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = fir80_pkg::COEF_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,   // sample_in
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata   // filtered_out
);
  import fir80_pkg::*;

  localparam int TAP_W  = $clog2(TAPS);
  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  state_t                        state_r, state_nxt;
  logic [TAP_W-1:0]              tap_r;
  logic signed [SAMPLE_BITS-1:0] dl_r [TAPS];
  logic                          out_tvalid_r;
  logic [SAMPLE_BITS-1:0]        out_data_r;
  logic                          accept;
  logic                          tap_last;
  logic                          out_free;
  logic                          load_out;
  mac_ctl_t                      ctl;
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          done;

  assign tap_last = (tap_r == TAP_W'(TAPS - 1));
  assign out_free = !out_tvalid_r || out_tready;
  assign coef     = COEF_BITS'(coef_at(int'(tap_r), COEF_BITS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_RUN;
      ST_RUN:   if (tap_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (done) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    accept      = in_tvalid && (state_r == ST_IDLE);
    ctl.clear   = accept;
    ctl.tap_vld = (state_r == ST_RUN);
    ctl.last    = tap_last;
    load_out    = (state_r == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tap_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_RUN) begin
        tap_r <= tap_last ? '0 : tap_r + TAP_W'(1);
      end else begin
        tap_r <= '0;
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Shift the new sample in on accept; rotate once per tap so that tap k sits at the head.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        dl_r[i] <= '0;
      end
    end else if (accept) begin
      dl_r[0] <= in_tdata[SAMPLE_BITS-1:0];
      for (int i = 1; i < TAPS; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end else if (state_r == ST_RUN) begin
      dl_r[TAPS-1] <= dl_r[0];
      for (int i = 0; i < TAPS - 1; i++) begin
        dl_r[i] <= dl_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= y;
    end
  end

  fir80_mac #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .samp  (dl_r[0]),
    .coef  (coef),
    .y     (y),
    .done  (done)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DATA_W'(out_data_r);

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the 80-tap low-pass FIR: predicted samples against the output stream.
`timescale 1ns / 100ps

module tb_top;
  import fir80_pkg::*;

  localparam int TAPS        = TAPS_DEF;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int COEF_BITS   = COEF_BITS_DEF;
  localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 475;

  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Bit-true model of the filter plus the queue of samples still due on the output.
  class fir_scoreboard;
    sample_t history [TAPS];
    sample_t due_q [$];
    int      errors;

    function new();
      foreach (history[i]) history[i] = '0;
      errors = 0;
    endfunction

    function longint coef_of(int idx);
      if (idx >= ROM_LEN) return 0;
      return ROM_HALF_TBL[(idx < ROM_HALF) ? idx : (ROM_LEN - 1 - idx)];
    endfunction

    function sample_t filter_sample(sample_t s);
      longint acc;
      longint y;
      acc = 0;
      for (int i = TAPS - 1; i > 0; i--) history[i] = history[i - 1];
      history[0] = s;
      for (int i = 0; i < TAPS; i++) acc += longint'(history[i]) * coef_of(i);
      // round half up, then floor shift
      y = (acc + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
      if (y > longint'(sample_t'(S_MAX))) y = longint'(sample_t'(S_MAX));
      if (y < longint'(sample_t'(S_MIN))) y = longint'(sample_t'(S_MIN));
      return sample_t'(y);
    endfunction

    function void note_sample(logic [DATA_W-1:0] beat);
      due_q.push_back(filter_sample(sample_t'(beat[SAMPLE_BITS-1:0])));
    endfunction

    function void check_result(logic [DATA_W-1:0] beat);
      sample_t got;
      sample_t want;
      got = sample_t'(beat[SAMPLE_BITS-1:0]);
      if (due_q.size() == 0) begin
        $error("filtered_out beat with nothing pending: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got !== want) begin
        $error("filtered_out mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;

  fir_scoreboard sb;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            quiet_cycles   = 0;

  always #2 clk = ~clk;

  fir_lowpass_80_tap_unit #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Beat monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_sample(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    // now and then a long gap, so that idle spans land anywhere in the tap sweep
    if (send_idle_pct != 0 && $urandom_range(7) == 0) gap += $urandom_range(1, 100);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Step past a clock edge first so that the monitor has logged the last accepted beat.
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Line up full-scale samples with the coefficient signs to drive the sum past the limits.
  task automatic send_saturating_run(input bit negative);
    for (int n = 0; n < TAPS; n++) begin
      if ((sb.coef_of(n) >= 0) ^ negative) begin
        send_sample(S_MAX - SAMPLE_BITS'($urandom_range(0, 3)));
      end else begin
        send_sample(S_MIN + SAMPLE_BITS'($urandom_range(0, 3)));
      end
    end
  endtask

  // Isolated pulse then zeros: walks the pulse past the first len coefficients.
  task automatic send_pulse(input int len);
    send_sample($urandom_range(1) ? S_MAX : S_MIN);
    repeat (len - 1) send_sample('0);
  endtask

  task automatic send_random_run(input int len);
    logic [SAMPLE_BITS-1:0] v;
    repeat (len) begin
      case ($urandom_range(3))
        0: v = SAMPLE_BITS'($signed($urandom_range(0, 2000)) - 1000);
        1: v = $urandom_range(1) ? S_MAX - SAMPLE_BITS'($urandom_range(0, 255))
                                 : S_MIN + SAMPLE_BITS'($urandom_range(0, 255));
        default: v = SAMPLE_BITS'($urandom);
      endcase
      send_sample(v);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int sent;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      case ($urandom_range(5))
        0: begin
          send_saturating_run(1'($urandom_range(1)));
          sent += TAPS;
        end
        1: begin
          len = $urandom_range(10, TAPS + 5);
          send_pulse(len);
          sent += len;
        end
        default: begin
          len = $urandom_range(1, 40);
          send_random_run(len);
          sent += len;
        end
      endcase
    end
    // hold off until every pending result is out
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, unit steps, both extremes, half scale, alternating bit and nibble patterns
    send_sample('0);
    send_sample(SAMPLE_BITS'(1));
    send_sample(SAMPLE_BITS'(-1));
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
    send_sample(24'h400000);
    send_sample(24'hC00000);
    send_sample(SAMPLE_BITS'(-2));
    send_sample(24'h0F0F0F);
    send_sample(24'hF0F0F0);
    send_sample(S_MAX);
    send_sample('0);
    send_sample(S_MIN);
    send_sample('0);
    in_tvalid <= 1'b0;
    wait_drained();

    run_phase(0, 0);
    run_phase(55, 0);
    run_phase(0, 55);
    run_phase(9, 9);

    wait_drained();
    repeat (TAPS + 20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("filtered_out results missing: expected %0d more, actual 0", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== fir_lowpass_80_tap_unit.f =====
rtl/fir80_pkg.sv
rtl/fir80_mac.sv
rtl/fir_lowpass_80_tap_unit.sv
bench/tb_top.sv
